// File: rtl/e2r_pkg.sv
package e2r_pkg;

    localparam int ANGLE_W  = 16;
    localparam int ENTRY_W  = 16;
    localparam int DP_FB    = 30;
    localparam int TRIG_FB  = 20;
    localparam int TABLE_LEN = 24;
    localparam int DP_W     = 34;
    localparam int TRIG_W   = 22;
    localparam logic signed [DP_W-1:0] GAIN_Q30 = 34'sd652032874;

    typedef logic signed [ANGLE_W-1:0] t_angle;
    typedef logic signed [ENTRY_W-1:0] t_entry;
    typedef logic signed [TRIG_W-1:0]  t_trig;

    typedef struct packed {
        t_angle yaw_angle;
        t_angle pitch_angle;
        t_angle roll_angle;
    } t_attitude;

    typedef struct packed {
        t_entry row0_col0;
        t_entry row0_col1;
        t_entry row0_col2;
        t_entry row1_col0;
        t_entry row1_col1;
        t_entry row1_col2;
        t_entry row2_col0;
        t_entry row2_col1;
        t_entry row2_col2;
    } t_matrix;

    typedef struct packed {
        t_trig c;
        t_trig s;
    } t_sincos;

    function automatic logic [31:0] atan_bam(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/e2r_stream_if.sv
interface e2r_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/e2r_to_bam.sv
module e2r_to_bam #(
    parameter int ANGLE_FRAC_BITS = 6
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  e2r_pkg::t_angle       i_angle,
    output logic [31:0]           o_bam
);
    import e2r_pkg::*;

    // 360*2^F = 45*2^(F+3): |a| = 45*q + r gives q*2^(29-F) plus a table term for r
    localparam int          SH      = 29 - ANGLE_FRAC_BITS;
    localparam longint      DEN     = longint'(360) << ANGLE_FRAC_BITS;
    localparam int          NREM    = 45;
    // ceil(2^21/45), exact quotient for |a| <= 2^15
    localparam logic [16:0] RECIP45 = 17'd46604;

    logic [31:0] w_tbl [NREM];
    logic [15:0] w_mag;
    logic [30:0] w_prod;
    logic [9:0]  w_q;
    logic [15:0] w_qx45;
    logic [5:0]  w_r;
    logic        r_neg;
    logic [9:0]  r_q;
    logic [5:0]  r_r;
    logic [31:0] w_b;

    // rounded binary angle of r/45 of a turn step, halves away from zero
    for (genvar k = 0; k < NREM; k++) begin : g_tbl
        assign w_tbl[k] = 32'(((longint'(k) << 32) + DEN / 2) / DEN);
    end

    assign w_mag  = i_angle[15] ? 16'(-i_angle) : 16'(i_angle);
    assign w_prod = 31'(w_mag) * 31'(RECIP45);
    assign w_q    = 10'(w_prod >> 21);
    assign w_qx45 = 16'(w_q) * 16'(NREM);
    assign w_r    = 6'(w_mag - w_qx45);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg <= i_angle[15];
            r_q   <= w_q;
            r_r   <= w_r;
        end
    end

    assign w_b = (32'(r_q) << SH) + w_tbl[r_r];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_bam <= r_neg ? (32'd0 - w_b) : w_b;
        end
    end
endmodule

// File: rtl/e2r_cordic.sv
module e2r_cordic #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [31:0]          i_bam,
    output e2r_pkg::t_sincos     o_sc
);
    import e2r_pkg::*;

    localparam int N = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

    logic signed [DP_W-1:0] r_x [N+1];
    logic signed [DP_W-1:0] r_y [N+1];
    logic signed [32:0]     r_z [N+1];
    logic                   r_neg [N+1];
    logic [31:0]            w_b;

    assign w_b = (i_bam[31:30] == 2'b01 || i_bam[31:30] == 2'b10) ?
                 i_bam + 32'h8000_0000 : i_bam;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= GAIN_Q30;
            r_y[0]   <= '0;
            r_z[0]   <= 33'(signed'(w_b));
            r_neg[0] <= (i_bam[31:30] == 2'b01 || i_bam[31:30] == 2'b10);
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_stage
        logic signed [DP_W-1:0] w_dx, w_dy;
        logic signed [32:0]     w_a;
        assign w_dx = r_y[g] >>> g;
        assign w_dy = r_x[g] >>> g;
        assign w_a  = 33'(atan_bam(g));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[g+1] <= r_neg[g];
                if (!r_z[g][32]) begin
                    r_x[g+1] <= r_x[g] - w_dx;
                    r_y[g+1] <= r_y[g] + w_dy;
                    r_z[g+1] <= r_z[g] - w_a;
                end else begin
                    r_x[g+1] <= r_x[g] + w_dx;
                    r_y[g+1] <= r_y[g] - w_dy;
                    r_z[g+1] <= r_z[g] + w_a;
                end
            end
        end
    end

    logic signed [DP_W-1:0] w_xr, w_yr;
    assign w_xr = (r_x[N] + DP_W'(1 << (DP_FB - TRIG_FB - 1))) >>> (DP_FB - TRIG_FB);
    assign w_yr = (r_y[N] + DP_W'(1 << (DP_FB - TRIG_FB - 1))) >>> (DP_FB - TRIG_FB);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_sc.c <= r_neg[N] ? TRIG_W'(-w_xr) : TRIG_W'(w_xr);
            o_sc.s <= r_neg[N] ? TRIG_W'(-w_yr) : TRIG_W'(w_yr);
        end
    end

    logic unused;
    assign unused = ^{r_z[N]};
endmodule

// File: rtl/e2r_matrix.sv
module e2r_matrix #(
    parameter int OUT_FRAC_BITS = 14
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  e2r_pkg::t_sincos  i_y,
    input  e2r_pkg::t_sincos  i_p,
    input  e2r_pkg::t_sincos  i_r,
    output e2r_pkg::t_matrix  o_m
);
    import e2r_pkg::*;

    localparam int P2_W = 2 * TRIG_W;
    localparam int P3_W = 3 * TRIG_W;
    localparam int SH   = 3 * TRIG_FB - OUT_FRAC_BITS;

    // stage 1: pair products
    logic signed [P2_W-1:0] r_cycp, r_sycp, r_cpsr, r_cpcr, r_sycr, r_cycr, r_sysr, r_cysr;
    logic signed [P2_W-1:0] r_cysp, r_sysp;
    t_trig r_sr, r_cr, r_sp;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cycp <= i_y.c * i_p.c;
            r_sycp <= i_y.s * i_p.c;
            r_cpsr <= i_p.c * i_r.s;
            r_cpcr <= i_p.c * i_r.c;
            r_sycr <= i_y.s * i_r.c;
            r_cycr <= i_y.c * i_r.c;
            r_sysr <= i_y.s * i_r.s;
            r_cysr <= i_y.c * i_r.s;
            r_cysp <= i_y.c * i_p.s;
            r_sysp <= i_y.s * i_p.s;
            r_sr   <= i_r.s;
            r_cr   <= i_r.c;
            r_sp   <= i_p.s;
        end
    end

    // stage 2: triple products (44x22, split in two halves)
    logic signed [TRIG_W-1:0] w_cysp_h, w_sysp_h;
    logic signed [TRIG_W:0]   w_cysp_l, w_sysp_l;
    assign w_cysp_h = r_cysp[P2_W-1:TRIG_W];
    assign w_sysp_h = r_sysp[P2_W-1:TRIG_W];
    assign w_cysp_l = {1'b0, r_cysp[TRIG_W-1:0]};
    assign w_sysp_l = {1'b0, r_sysp[TRIG_W-1:0]};

    logic signed [P2_W-1:0] r_t01h, r_t02h, r_t11h, r_t12h;
    logic signed [P2_W:0]   r_t01l, r_t02l, r_t11l, r_t12l;
    logic signed [P2_W-1:0] q_cycp, q_sycp, q_cpsr, q_cpcr, q_sycr, q_cycr, q_sysr, q_cysr;
    t_trig q_sp;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t01h <= w_cysp_h * r_sr;
            r_t01l <= w_cysp_l * r_sr;
            r_t02h <= w_cysp_h * r_cr;
            r_t02l <= w_cysp_l * r_cr;
            r_t11h <= w_sysp_h * r_sr;
            r_t11l <= w_sysp_l * r_sr;
            r_t12h <= w_sysp_h * r_cr;
            r_t12l <= w_sysp_l * r_cr;
            q_cycp <= r_cycp; q_sycp <= r_sycp; q_cpsr <= r_cpsr; q_cpcr <= r_cpcr;
            q_sycr <= r_sycr; q_cycr <= r_cycr; q_sysr <= r_sysr; q_cysr <= r_cysr;
            q_sp <= r_sp;
        end
    end

    function automatic t_entry fin(input logic signed [P3_W+1:0] v);
        logic signed [P3_W+1:0] r;
        logic signed [P3_W+1:0] lim;
        r   = (v + ((P3_W+2)'(1) <<< (SH - 1))) >>> SH;
        lim = (P3_W+2)'(1) <<< OUT_FRAC_BITS;
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return t_entry'(r);
    endfunction

    function automatic logic signed [P3_W+1:0] up2(input logic signed [P2_W-1:0] v);
        return (P3_W+2)'(v) <<< TRIG_FB;
    endfunction

    function automatic logic signed [P3_W+1:0] tri3(input logic signed [P2_W-1:0] h,
                                                   input logic signed [P2_W:0] l);
        return ((P3_W+2)'(h) <<< TRIG_W) + (P3_W+2)'(l);
    endfunction

    // stage 3: sums, round, saturate
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_m.row0_col0 <= fin(up2(q_cycp));
            o_m.row0_col1 <= fin(tri3(r_t01h, r_t01l) - up2(q_sycr));
            o_m.row0_col2 <= fin(up2(q_sysr) + tri3(r_t02h, r_t02l));
            o_m.row1_col0 <= fin(up2(q_sycp));
            o_m.row1_col1 <= fin(up2(q_cycr) + tri3(r_t11h, r_t11l));
            o_m.row1_col2 <= fin(tri3(r_t12h, r_t12l) - up2(q_cysr));
            o_m.row2_col0 <= fin(-((P3_W+2)'(q_sp) <<< (2 * TRIG_FB)));
            o_m.row2_col1 <= fin(up2(q_cpsr));
            o_m.row2_col2 <= fin(up2(q_cpcr));
        end
    end
endmodule

// File: rtl/euler_to_rotation_matrix.sv
// channel   dir  payload
// s_att     in   yaw_angle, pitch_angle, roll_angle (1/64 deg)
// m_mtx     out  nine Q2.14 entries, row major
//
// BAM, CORDIC and matrix stages; one word per cycle unless output stalls.
// Whole pipeline advances when the output stage is empty or drained.
// i_rst_n synchronous: clears valid bits only.
// Output stall holds every stage; nothing lost or repeated.
module euler_to_rotation_matrix #(
    parameter int CORDIC_STAGES   = 16,
    parameter int ANGLE_FRAC_BITS = 6,
    parameter int OUT_FRAC_BITS   = 14
) (
    input  logic i_clk,
    input  logic i_rst_n,
    e2r_stream_if.sink   s_att,
    e2r_stream_if.source m_mtx
);
    import e2r_pkg::*;

    localparam int N   = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
    localparam int LAT = N + 7;

    logic       w_en;
    logic [LAT-1:0] r_vld;
    t_attitude  w_in;
    logic [31:0] w_by, w_bp, w_br;
    t_sincos    w_sy, w_sp, w_sr;

    assign w_en = !m_mtx.valid || m_mtx.ready;
    assign s_att.ready = w_en;
    assign w_in = s_att.data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], s_att.valid};
        end
    end
    assign m_mtx.valid = r_vld[LAT-1];

    e2r_to_bam #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_by (
        .i_clk(i_clk), .i_en(w_en), .i_angle(w_in.yaw_angle), .o_bam(w_by));
    e2r_to_bam #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_bp (
        .i_clk(i_clk), .i_en(w_en), .i_angle(w_in.pitch_angle), .o_bam(w_bp));
    e2r_to_bam #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_br (
        .i_clk(i_clk), .i_en(w_en), .i_angle(w_in.roll_angle), .o_bam(w_br));

    e2r_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cy (
        .i_clk(i_clk), .i_en(w_en), .i_bam(w_by), .o_sc(w_sy));
    e2r_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cp (
        .i_clk(i_clk), .i_en(w_en), .i_bam(w_bp), .o_sc(w_sp));
    e2r_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cr (
        .i_clk(i_clk), .i_en(w_en), .i_bam(w_br), .o_sc(w_sr));

    e2r_matrix #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_mtx (
        .i_clk(i_clk), .i_en(w_en), .i_y(w_sy), .i_p(w_sp), .i_r(w_sr),
        .o_m(m_mtx.data));

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_mtx.valid && !m_mtx.ready |=> $stable(r_vld))
        else $error("pipeline moved during stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_mtx.valid |-> s_att.ready)
        else $error("not ready with empty output");
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_att.valid && s_att.ready |=> r_vld[0])
        else $error("accepted word lost");
endmodule

// File: verif/euler_to_rotation_matrix_test.sv
`timescale 1ns / 100ps

module euler_to_rotation_matrix_test;
    import e2r_pkg::*;

    localparam int STAGES    = 16;
    localparam int ANG_FB    = 6;
    localparam int OUT_FB    = 14;
    localparam int LATENCY   = STAGES + 7;
    localparam int IDLE_LIMIT = 5000;
    localparam int LONG_HOLD = 200;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    e2r_stream_if #(.T(t_attitude)) att_if ();
    e2r_stream_if #(.T(t_matrix))   mtx_if ();

    euler_to_rotation_matrix #(
        .CORDIC_STAGES(STAGES),
        .ANGLE_FRAC_BITS(ANG_FB),
        .OUT_FRAC_BITS(OUT_FB)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_att(att_if.sink),
        .m_mtx(mtx_if.source)
    );

    always #2 i_clk = ~i_clk;

    t_matrix matrix_q[$];
    int      n_fail = 0;
    int      n_sent = 0;
    int      n_got = 0;
    int      idle_cycles = 0;
    bit      hold_rx = 1'b0;
    bit      rx_stall_on = 1'b1;
    bit      gaps_on = 1'b1;

    initial begin
        att_if.valid = 1'b0;
        att_if.data  = '0;
        mtx_if.ready = 1'b0;
    end

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic [31:0] deg_to_bam(t_angle a);
        longint den;
        longint mag;
        longint q;
        logic [31:0] b;
        den = longint'(360) << ANG_FB;
        mag = (a < 0) ? -longint'(a) : longint'(a);
        q   = ((mag << 32) + den / 2) / den;
        b   = q[31:0];
        return (a < 0) ? (32'd0 - b) : b;
    endfunction

    function automatic void cordic_sincos(input logic [31:0] bam, output longint c,
                                          output longint s);
        bit     flip;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        flip = 1'b0;
        x = longint'(GAIN_Q30);
        y = 0;
        if (bam[31:30] == 2'd1 || bam[31:30] == 2'd2) begin
            bam  = bam + 32'h8000_0000;
            flip = 1'b1;
        end
        z = longint'($signed(bam));
        for (int i = 0; i < STAGES && i < TABLE_LEN; i++) begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - longint'(atan_bam(i));
            end else begin
                x = x + dx; y = y - dy; z = z + longint'(atan_bam(i));
            end
        end
        x = shr_floor(x + (longint'(1) << (DP_FB - TRIG_FB - 1)), DP_FB - TRIG_FB);
        y = shr_floor(y + (longint'(1) << (DP_FB - TRIG_FB - 1)), DP_FB - TRIG_FB);
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic t_entry round_entry(longint v60);
        int     sh;
        longint lim;
        longint r;
        sh  = 3 * TRIG_FB - OUT_FB;
        lim = longint'(1) << OUT_FB;
        r   = shr_floor(v60 + (longint'(1) << (sh - 1)), sh);
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r[ENTRY_W-1:0];
    endfunction

    function automatic t_matrix attitude_matrix(t_attitude a);
        longint cy, sy, cp, sp, cr, sr;
        longint k;
        t_matrix m;
        k = longint'(1) << TRIG_FB;
        cordic_sincos(deg_to_bam(a.yaw_angle), cy, sy);
        cordic_sincos(deg_to_bam(a.pitch_angle), cp, sp);
        cordic_sincos(deg_to_bam(a.roll_angle), cr, sr);
        m.row0_col0 = round_entry(cy * cp * k);
        m.row0_col1 = round_entry(cy * sp * sr - sy * cr * k);
        m.row0_col2 = round_entry(sy * sr * k + cy * sp * cr);
        m.row1_col0 = round_entry(sy * cp * k);
        m.row1_col1 = round_entry(cy * cr * k + sy * sp * sr);
        m.row1_col2 = round_entry(sy * sp * cr - cy * sr * k);
        m.row2_col0 = round_entry(-sp * k * k);
        m.row2_col1 = round_entry(cp * sr * k);
        m.row2_col2 = round_entry(cp * cr * k);
        return m;
    endfunction

    // sender: one word, then random gap if enabled
    task automatic send_attitude(input t_angle yaw, input t_angle pitch, input t_angle roll);
        t_attitude a;
        a.yaw_angle = yaw;
        a.pitch_angle = pitch;
        a.roll_angle = roll;
        att_if.valid <= 1'b1;
        att_if.data  <= a;
        @(posedge i_clk);
        while (!att_if.ready) @(posedge i_clk);
        matrix_q.push_back(attitude_matrix(a));
        n_sent++;
        if (gaps_on && $urandom_range(0, 7) == 0) begin
            att_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic end_burst();
        att_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (matrix_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_angle rand_angle();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return t_angle'($urandom());
        return t_angle'($urandom_range(0, 46080) - 23040);
    endfunction

    // receiver stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_rx) begin
            mtx_if.ready <= 1'b0;
        end else if (rx_stall_on) begin
            mtx_if.ready <= ($urandom_range(0, 3) != 0);
        end else begin
            mtx_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_matrix got;
        t_matrix want;
        if (i_rst_n && mtx_if.valid && mtx_if.ready) begin
            got = mtx_if.data;
            n_got++;
            if (matrix_q.size() == 0) begin
                $error("unexpected word %h", got);
                n_fail++;
            end else begin
                want = matrix_q.pop_front();
                if (got.row0_col0 !== want.row0_col0) begin
                    $error("row0_col0 exp %0d got %0d", want.row0_col0, got.row0_col0);
                    n_fail++;
                end
                if (got.row0_col1 !== want.row0_col1) begin
                    $error("row0_col1 exp %0d got %0d", want.row0_col1, got.row0_col1);
                    n_fail++;
                end
                if (got.row0_col2 !== want.row0_col2) begin
                    $error("row0_col2 exp %0d got %0d", want.row0_col2, got.row0_col2);
                    n_fail++;
                end
                if (got.row1_col0 !== want.row1_col0) begin
                    $error("row1_col0 exp %0d got %0d", want.row1_col0, got.row1_col0);
                    n_fail++;
                end
                if (got.row1_col1 !== want.row1_col1) begin
                    $error("row1_col1 exp %0d got %0d", want.row1_col1, got.row1_col1);
                    n_fail++;
                end
                if (got.row1_col2 !== want.row1_col2) begin
                    $error("row1_col2 exp %0d got %0d", want.row1_col2, got.row1_col2);
                    n_fail++;
                end
                if (got.row2_col0 !== want.row2_col0) begin
                    $error("row2_col0 exp %0d got %0d", want.row2_col0, got.row2_col0);
                    n_fail++;
                end
                if (got.row2_col1 !== want.row2_col1) begin
                    $error("row2_col1 exp %0d got %0d", want.row2_col1, got.row2_col1);
                    n_fail++;
                end
                if (got.row2_col2 !== want.row2_col2) begin
                    $error("row2_col2 exp %0d got %0d", want.row2_col2, got.row2_col2);
                    n_fail++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((att_if.valid && att_if.ready) || (mtx_if.valid && mtx_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
            $display("euler_to_rotation_matrix test failed");
            $finish;
        end
    end

    task automatic test_directed();
        // zero, quadrant edges, range limits, rounding halves, wrap
        send_attitude(16'sd0, 16'sd0, 16'sd0);
        send_attitude(16'sd5760, 16'sd0, 16'sd0);
        send_attitude(16'sd11520, 16'sd5760, 16'sd0);
        send_attitude(16'sd17280, -16'sd5760, 16'sd11520);
        send_attitude(16'sd23040, 16'sd23040, 16'sd23040);
        send_attitude(-16'sd23040, -16'sd23040, -16'sd23040);
        send_attitude(16'sd5759, 16'sd5761, 16'sd17279);
        send_attitude(-16'sd5760, 16'sd5760, -16'sd11520);
        send_attitude(16'sd1, -16'sd1, 16'sd45);
        send_attitude(16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_attitude(-16'sh8000, -16'sh8000, -16'sh8000);
        send_attitude(16'sh5555, -16'sh5556, 16'sh2aaa);
        send_attitude(16'sd2880, 16'sd2880, 16'sd2880);
        send_attitude(-16'sd2880, 16'sd8640, 16'sd14400);
        send_attitude(16'sd11519, 16'sd11521, -16'sd17281);
        send_attitude(16'sd20160, 16'sd5760, 16'sd5760);
        send_attitude(16'sd0, -16'sd5760, 16'sd23039);
        end_burst();
    endtask

    task automatic test_random(input int n);
        int left;
        int burst;
        left = n;
        while (left > 0) begin
            burst = $urandom_range(1, 40);
            if (burst > left) burst = left;
            gaps_on = ($urandom_range(0, 2) != 0);
            for (int i = 0; i < burst; i++) begin
                send_attitude(rand_angle(), rand_angle(), rand_angle());
            end
            left -= burst;
            end_burst();
            repeat ($urandom_range(0, 4)) @(posedge i_clk);
            rx_stall_on = ($urandom_range(0, 3) != 0);
        end
        gaps_on = 1'b1;
        rx_stall_on = 1'b1;
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_rx = 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_rx = 1'b0;
            end
            begin
                gaps_on = 1'b0;
                for (int i = 0; i < 60; i++) send_attitude(rand_angle(), rand_angle(),
                                                           rand_angle());
                end_burst();
                gaps_on = 1'b1;
            end
        join
        wait_drained();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(700);
        test_backpressure();
        test_random(790);
        wait_drained();
        repeat (LATENCY * 4) @(posedge i_clk);
        $display("covered %0d attitudes (%0d matrices), quadrant edges, range", n_sent, n_got);
        $display("limits, full 16-bit wrap, output stall fill and input pauses");
        if (n_fail == 0 && matrix_q.size() == 0) begin
            $display("euler_to_rotation_matrix test passed");
        end else begin
            $display("euler_to_rotation_matrix test failed");
        end
        $finish;
    end
endmodule

// File: euler_to_rotation_matrix.f
rtl/e2r_pkg.sv
rtl/e2r_stream_if.sv
rtl/e2r_to_bam.sv
rtl/e2r_cordic.sv
rtl/e2r_matrix.sv
rtl/euler_to_rotation_matrix.sv
verif/euler_to_rotation_matrix_test.sv
